/* rtl/core/spfp_pkg.sv */
// Shared widths, payload types and index helpers for the support plane core.
// No dependencies; every other file of the core imports this package.
package spfp_pkg;

    // Coordinate and direction formats
    localparam int CW    = 24;              // Q8.16 coordinate
    localparam int CFB   = 16;              // coordinate fraction bits
    localparam int DFB   = 30;              // direction fraction bits
    localparam int DIRW  = DFB + 2;         // signed Q1.30 direction
    localparam int THRW  = 10;              // zeroing threshold
    localparam int SVW   = CW + 2;          // support value

    // Exact normal path
    localparam int DW    = CW + 1;          // a - b
    localparam int PW    = 2 * CW;          // cross product terms
    localparam int XW    = PW + 1;          // cross product components
    localparam int LOW   = 25;              // low slice of a cross component
    localparam int HIW   = XW - LOW;        // high slice of a cross component
    localparam int NW    = DW + XW + 1;     // normal components

    // Normalisation path
    localparam int MW    = 31;              // scaled magnitude
    localparam int SQW   = 2 * MW;          // square of a scaled magnitude
    localparam int SUMW  = 64;              // sum of squares
    localparam int QW    = SUMW / 2;        // integer square root
    localparam int TW    = DFB + 1;         // quotient (unit component magnitude)
    localparam int NUMW  = MW + DFB + 1;    // rounded dividend
    localparam int SQ_STAGES  = QW;         // one root bit per stage
    localparam int DIV_STAGES = TW;         // one quotient bit per stage
    localparam int CHUNK  = 15;             // leading-one search slice
    localparam int NCHUNK = NW / CHUNK;
    localparam int LENW   = 4;              // bit length inside one slice
    localparam int MAXBW  = 7;              // bit length of a normal component
    localparam int SHW    = 6;              // normalising shift
    localparam int PRW    = DIRW + CW;      // direction times coordinate
    localparam int DOTW   = PRW + 2;        // dot product

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef logic [CW-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] a;
        coord_t [2:0] b;
    } pair_t;

    // Classified normal as queued for the back end
    typedef struct packed {
        logic                   deg;
        logic [2:0]             neg;
        logic [2:0][NW-1:0]     mag;
        coord_t [2:0]           a;
    } qent_t;

    typedef struct packed {
        logic  valid;
        qent_t ent;
    } qpush_t;

    // Side data that travels along the root and divide units
    typedef struct packed {
        logic                   deg;
        logic [2:0]             neg;
        logic [2:0][MW-1:0]     m;
        coord_t [2:0]           a;
    } side_t;

    // Left operand index of product k; products pair up as (0,1) (2,3) (4,5)
    function automatic int prod_l(input int k);
        int r;
        case (k)
            0:       r = 1;
            1:       r = 2;
            2:       r = 2;
            3:       r = 0;
            4:       r = 0;
            5:       r = 1;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Right operand index of product k
    function automatic int prod_r(input int k);
        int r;
        case (k)
            0:       r = 2;
            1:       r = 1;
            2:       r = 0;
            3:       r = 2;
            4:       r = 1;
            5:       r = 0;
            default: r = 0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/spfp_front.sv */
// Front end: accepts point pairs and forms the exact normal, its signs and magnitudes.
// Six stage pipeline into the queue; depends on spfp_pkg.
module spfp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  spfp_pkg::pair_t pair,
    input  logic            q_full,
    output spfp_pkg::qpush_t push
);
    import spfp_pkg::*;

    logic                   adv;
    logic [5:0]             v_reg;
    logic signed [CW-1:0]   ai [3];
    logic signed [CW-1:0]   bi [3];
    logic signed [DW-1:0]   d1_reg [3];
    logic signed [DW-1:0]   d2_reg [3];
    logic signed [PW-1:0]   p1_reg [6];
    logic signed [XW-1:0]   c2_reg [3];
    logic signed [DW+LOW:0] lo3_reg [6];
    logic signed [DW+HIW-1:0] hi3_reg [6];
    logic signed [NW-1:0]   f4_reg [6];
    logic signed [NW-1:0]   n5_reg [3];
    logic [2:0][CW-1:0]     a_reg [5];
    qent_t                  e6_reg;
    qent_t                  e6_next;

    // Advance while the last stage is empty or the queue has room
    assign adv      = !v_reg[5] || !q_full;
    assign in_stall = !adv;
    assign push.valid = v_reg[5] && !q_full;
    assign push.ent   = e6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ai[k] = pair.a[k];
            bi[k] = pair.b[k];
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Classify the normal: sign, magnitude, all-zero
    always_comb
    begin
        e6_next.a   = a_reg[4];
        e6_next.deg = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            e6_next.neg[k] = n5_reg[k][NW-1];
            e6_next.mag[k] = n5_reg[k][NW-1] ? NW'(-n5_reg[k]) : NW'(n5_reg[k]);
            if (n5_reg[k] != '0)
            begin
                e6_next.deg = 1'b0;
            end
        end
    end

    // Arithmetic pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // difference and cross product terms
            for (int k = 0; k < 3; k++)
            begin
                d1_reg[k] <= DW'(ai[k]) - DW'(bi[k]);
            end
            for (int k = 0; k < 6; k++)
            begin
                p1_reg[k] <= ai[prod_l(k)] * bi[prod_r(k)];
            end
            a_reg[0] <= pair.a;
            for (int k = 1; k < 5; k++)
            begin
                a_reg[k] <= a_reg[k-1];
            end
            // cross product components
            for (int k = 0; k < 3; k++)
            begin
                c2_reg[k] <= XW'(p1_reg[2*k]) - XW'(p1_reg[2*k+1]);
                d2_reg[k] <= d1_reg[k];
            end
            // split products of difference and cross components
            for (int k = 0; k < 6; k++)
            begin
                lo3_reg[k] <= d2_reg[prod_l(k)]
                              * $signed({1'b0, c2_reg[prod_r(k)][LOW-1:0]});
                hi3_reg[k] <= d2_reg[prod_l(k)]
                              * $signed(c2_reg[prod_r(k)][XW-1:LOW]);
            end
            // join the halves
            for (int k = 0; k < 6; k++)
            begin
                f4_reg[k] <= NW'($signed({hi3_reg[k], {LOW{1'b0}}})) + NW'(lo3_reg[k]);
            end
            // exact normal
            for (int k = 0; k < 3; k++)
            begin
                n5_reg[k] <= f4_reg[2*k] - f4_reg[2*k+1];
            end
            e6_reg <= e6_next;
        end
    end

endmodule

/* rtl/core/spfp_queue.sv */
// Short queue that decouples the front end from the back end.
// Depends on spfp_pkg for the entry type and depth.
module spfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  spfp_pkg::qpush_t  push,
    input  logic              pop,
    output spfp_pkg::qent_t   head,
    output logic              full,
    output logic              empty
);
    import spfp_pkg::*;

    qent_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;

    assign full  = cnt_reg == (QAW+1)'(QDEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rp_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wp_reg] <= push.ent;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push.valid && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push.valid && pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/spfp_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
// Depends on spfp_pkg for widths.
module spfp_sqrt (
    input  logic                          clk,
    input  logic                          en,
    input  logic [spfp_pkg::SUMW-1:0]     rad,
    output logic [spfp_pkg::QW-1:0]       root
);
    import spfp_pkg::*;

    logic [SUMW-1:0] rad_reg  [SQ_STAGES];
    logic [QW+1:0]   rem_reg  [SQ_STAGES];
    logic [QW-1:0]   root_reg [SQ_STAGES];
    logic [SUMW-1:0] rad_in   [SQ_STAGES];
    logic [QW+1:0]   rem_in   [SQ_STAGES];
    logic [QW-1:0]   root_in  [SQ_STAGES];
    logic [QW+3:0]   cur      [SQ_STAGES];
    logic [QW+3:0]   trial    [SQ_STAGES];
    logic [SUMW-1:0] rad_next [SQ_STAGES];
    logic [QW+1:0]   rem_next [SQ_STAGES];
    logic [QW-1:0]   root_next[SQ_STAGES];

    assign root = root_reg[SQ_STAGES-1];

    // Bring down two radicand bits and try the next root bit
    always_comb
    begin
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            if (k == 0)
            begin
                rad_in[k]  = rad;
                rem_in[k]  = '0;
                root_in[k] = '0;
            end
            else
            begin
                rad_in[k]  = rad_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            cur[k]      = {rem_in[k], rad_in[k][SUMW-1 -: 2]};
            trial[k]    = (QW+4)'({root_in[k], 2'b01});
            rad_next[k] = rad_in[k] << 2;
            if (cur[k] >= trial[k])
            begin
                rem_next[k]  = (QW+2)'(cur[k] - trial[k]);
                root_next[k] = {root_in[k][QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = (QW+2)'(cur[k]);
                root_next[k] = {root_in[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

endmodule

/* rtl/core/spfp_div.sv */
// Pipelined restoring divider for one direction lane, one quotient bit per stage.
// Needs the top dividend bits below the divisor; depends on spfp_pkg.
module spfp_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [spfp_pkg::NUMW-1:0]   num,
    input  logic [spfp_pkg::QW-1:0]     den,
    output logic [spfp_pkg::TW-1:0]     quo
);
    import spfp_pkg::*;

    logic [QW-1:0] rem_reg  [DIV_STAGES];
    logic [TW-1:0] low_reg  [DIV_STAGES];
    logic [TW-1:0] quo_reg  [DIV_STAGES];
    logic [QW-1:0] den_reg  [DIV_STAGES];
    logic [QW-1:0] rem_in   [DIV_STAGES];
    logic [TW-1:0] low_in   [DIV_STAGES];
    logic [TW-1:0] quo_in   [DIV_STAGES];
    logic [QW-1:0] den_in   [DIV_STAGES];
    logic [QW:0]   cur      [DIV_STAGES];
    logic [QW-1:0] rem_next [DIV_STAGES];
    logic [TW-1:0] quo_next [DIV_STAGES];

    assign quo = quo_reg[DIV_STAGES-1];

    // Shift in one dividend bit and subtract where it fits
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in[k] = QW'(num[NUMW-1:TW]);
                low_in[k] = num[TW-1:0];
                quo_in[k] = '0;
                den_in[k] = den;
            end
            else
            begin
                rem_in[k] = rem_reg[k-1];
                low_in[k] = low_reg[k-1];
                quo_in[k] = quo_reg[k-1];
                den_in[k] = den_reg[k-1];
            end
            cur[k] = {rem_in[k], low_in[k][TW-1]};
            if (cur[k] >= {1'b0, den_in[k]})
            begin
                rem_next[k] = QW'(cur[k] - {1'b0, den_in[k]});
                quo_next[k] = {quo_in[k][TW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = QW'(cur[k]);
                quo_next[k] = {quo_in[k][TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_in[k] << 1;
                quo_reg[k] <= quo_next[k];
                den_reg[k] <= den_in[k];
            end
        end
    end

endmodule

/* rtl/core/spfp_back.sv */
// Back end: scales the normal, takes its length, divides to a unit vector,
// orients it and forms the support value. Uses spfp_sqrt, spfp_div and spfp_pkg.
module spfp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [spfp_pkg::THRW-1:0]         thr,
    input  logic                              q_empty,
    input  spfp_pkg::qent_t                   q_head,
    output logic                              q_pop,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_x,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_y,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_z,
    output logic signed [spfp_pkg::SVW-1:0]   support_value,
    output logic                              degenerate
);
    import spfp_pkg::*;

    localparam logic [TW-1:0]       LIM  = TW'(1) << DFB;
    localparam logic [DOTW-2:0]     HALF = (DOTW-1)'(1) << (DFB - 1);

    logic adv;

    // valids
    logic [5:0]           pv_reg;
    logic                 sv_reg [SQ_STAGES];
    logic                 v7_reg;
    logic                 dv_reg [DIV_STAGES];
    logic [4:0]           ov_reg;

    // scaling stages
    qent_t                e1_reg;
    qent_t                e2_reg;
    qent_t                e3_reg;
    logic [NCHUNK-1:0]    cnz_next;
    logic [NCHUNK-1:0]    cnz2_reg;
    logic [LENW-1:0]      clen_next [NCHUNK];
    logic [LENW-1:0]      clen2_reg [NCHUNK];
    logic [NW-1:0]        orw;
    logic [CHUNK-1:0]     chunk [NCHUNK];
    logic [MAXBW-1:0]     maxb;
    logic [SHW-1:0]       sh_next;
    logic [SHW-1:0]       sh3_reg;
    side_t                s4_next;
    side_t                s4_reg;
    side_t                s5_reg;
    side_t                s6_reg;
    logic [SQW-1:0]       sq5_reg [3];
    logic [SUMW-1:0]      sum6_reg;

    // root and divide
    side_t                ss_reg [SQ_STAGES];
    logic [QW-1:0]        root;
    logic [QW-1:0]        qfix;
    side_t                s7_reg;
    logic [QW-1:0]        q7_reg;
    logic [NUMW-1:0]      num7_reg [3];
    side_t                ds_reg [DIV_STAGES];
    logic [TW-1:0]        quo [3];

    // orientation stages
    logic [TW-1:0]        tc [3];
    logic signed [DIRW-1:0] dir1_next [3];
    logic signed [DIRW-1:0] dir1_reg [3];
    side_t                sd1_reg;
    logic signed [PRW-1:0]  prd2_reg [3];
    logic signed [DIRW-1:0] dir2_reg [3];
    logic                 deg2_reg;
    logic signed [DOTW-1:0] dot3_reg;
    logic signed [DIRW-1:0] dir3_reg [3];
    logic                 deg3_reg;
    logic [DOTW-2:0]      adot4_reg;
    logic signed [DIRW-1:0] dir4_reg [3];
    logic                 deg4_reg;
    logic [DOTW-2:0]      rnd;

    // Whole back end moves while the output register is free or being taken
    assign adv       = !ov_reg[4] || !out_stall;
    assign q_pop     = adv && !q_empty;
    assign out_valid = ov_reg[4];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            v7_reg <= 1'b0;
            ov_reg <= '0;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sv_reg[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            pv_reg    <= {pv_reg[4:0], !q_empty};
            sv_reg[0] <= pv_reg[5];
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
            v7_reg    <= sv_reg[SQ_STAGES-1];
            dv_reg[0] <= v7_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
            ov_reg <= {ov_reg[3:0], dv_reg[DIV_STAGES-1]};
        end
    end

    // Leading-one search, first half: per slice
    always_comb
    begin
        orw = e1_reg.mag[0] | e1_reg.mag[1] | e1_reg.mag[2];
        for (int j = 0; j < NCHUNK; j++)
        begin
            chunk[j]    = orw[j*CHUNK +: CHUNK];
            cnz_next[j] = |chunk[j];
            clen_next[j] = '0;
            for (int b = 0; b < CHUNK; b++)
            begin
                if (chunk[j][b])
                begin
                    clen_next[j] = LENW'(b + 1);
                end
            end
        end
    end

    // Leading-one search, second half: pick the top slice, derive the shift
    always_comb
    begin
        maxb = '0;
        for (int j = 0; j < NCHUNK; j++)
        begin
            if (cnz2_reg[j])
            begin
                maxb = MAXBW'(j * CHUNK) + MAXBW'(clen2_reg[j]);
            end
        end
        sh_next = (maxb > MAXBW'(MW)) ? SHW'(maxb - MAXBW'(MW)) : '0;
    end

    // Scale magnitudes below 2^31
    always_comb
    begin
        s4_next.deg = e3_reg.deg;
        s4_next.neg = e3_reg.neg;
        s4_next.a   = e3_reg.a;
        for (int k = 0; k < 3; k++)
        begin
            s4_next.m[k] = MW'(e3_reg.mag[k] >> sh3_reg);
        end
    end

    assign qfix = (root == '0) ? QW'(1) : root;

    // Saturate, threshold and sign the quotients
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tc[k] = (quo[k] > LIM) ? LIM : quo[k];
            if (tc[k] <= TW'(thr))
            begin
                tc[k] = '0;
            end
            dir1_next[k] = ds_reg[DIV_STAGES-1].neg[k] ? -DIRW'(tc[k]) : DIRW'(tc[k]);
        end
    end

    assign rnd = adot4_reg + HALF;

    // Data pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg <= q_head;
            e2_reg <= e1_reg;
            cnz2_reg <= cnz_next;
            for (int j = 0; j < NCHUNK; j++)
            begin
                clen2_reg[j] <= clen_next[j];
            end
            e3_reg  <= e2_reg;
            sh3_reg <= sh_next;
            s4_reg  <= s4_next;
            // squares
            s5_reg <= s4_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq5_reg[k] <= SQW'(s4_reg.m[k]) * SQW'(s4_reg.m[k]);
            end
            // sum of squares
            s6_reg   <= s5_reg;
            sum6_reg <= SUMW'(sq5_reg[0]) + SUMW'(sq5_reg[1]) + SUMW'(sq5_reg[2]);
            // side data alongside the root unit
            ss_reg[0] <= s6_reg;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                ss_reg[k] <= ss_reg[k-1];
            end
            // rounded dividends
            s7_reg <= ss_reg[SQ_STAGES-1];
            q7_reg <= qfix;
            for (int k = 0; k < 3; k++)
            begin
                num7_reg[k] <= NUMW'({ss_reg[SQ_STAGES-1].m[k], {DFB{1'b0}}})
                               + NUMW'(qfix >> 1);
            end
            // side data alongside the dividers
            ds_reg[0] <= s7_reg;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                ds_reg[k] <= ds_reg[k-1];
            end
            // unit direction
            sd1_reg <= ds_reg[DIV_STAGES-1];
            for (int k = 0; k < 3; k++)
            begin
                dir1_reg[k] <= dir1_next[k];
            end
            // dot product terms
            deg2_reg <= sd1_reg.deg;
            for (int k = 0; k < 3; k++)
            begin
                prd2_reg[k] <= dir1_reg[k] * $signed(sd1_reg.a[k]);
                dir2_reg[k] <= dir1_reg[k];
            end
            // dot product
            deg3_reg <= deg2_reg;
            dot3_reg <= DOTW'(prd2_reg[0]) + DOTW'(prd2_reg[1]) + DOTW'(prd2_reg[2]);
            for (int k = 0; k < 3; k++)
            begin
                dir3_reg[k] <= dir2_reg[k];
            end
            // flip towards the first point
            deg4_reg <= deg3_reg;
            if (dot3_reg[DOTW-1])
            begin
                adot4_reg <= (DOTW-1)'(-dot3_reg);
                for (int k = 0; k < 3; k++)
                begin
                    dir4_reg[k] <= -dir3_reg[k];
                end
            end
            else
            begin
                adot4_reg <= (DOTW-1)'(dot3_reg);
                for (int k = 0; k < 3; k++)
                begin
                    dir4_reg[k] <= dir3_reg[k];
                end
            end
            // round the support value; zero everything for a degenerate pair
            degenerate <= deg4_reg;
            if (deg4_reg)
            begin
                dir_x         <= '0;
                dir_y         <= '0;
                dir_z         <= '0;
                support_value <= '0;
            end
            else
            begin
                dir_x         <= dir4_reg[0];
                dir_y         <= dir4_reg[1];
                dir_z         <= dir4_reg[2];
                support_value <= SVW'(rnd >> DFB);
            end
        end
    end

    // Root of the sum of squares
    spfp_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (sum6_reg),
        .root (root)
    );

    // One divider per direction component
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        spfp_div u_div (
            .clk (clk),
            .en  (adv),
            .num (num7_reg[g]),
            .den (q7_reg),
            .quo (quo[g])
        );
    end

endmodule

/* rtl/core/support_plane_from_two_points_core.sv */
// Channel   Direction  Handshake           Payload
// config    in         cfg_we              cfg_wdata (zeroing threshold)
// points    in         in_valid/in_stall   first_x/y/z, second_x/y/z
// plane     out        out_valid/out_stall dir_x/y/z, support_value, degenerate
//
// One point pair is taken per cycle while in_stall is low. The root unit
// has 32 stages and each of the three dividers has 31 stages.
// Reset clears all valid state and the threshold to zero.
// An output stall freezes the back end; the four-entry queue then absorbs
// the front end before in_stall rises.
//
// Top level: threshold register, front end, queue and back end.
// Depends on spfp_pkg, spfp_front, spfp_queue and spfp_back.
module support_plane_from_two_points_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [spfp_pkg::THRW-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [spfp_pkg::CW-1:0]    first_x,
    input  logic signed [spfp_pkg::CW-1:0]    first_y,
    input  logic signed [spfp_pkg::CW-1:0]    first_z,
    input  logic signed [spfp_pkg::CW-1:0]    second_x,
    input  logic signed [spfp_pkg::CW-1:0]    second_y,
    input  logic signed [spfp_pkg::CW-1:0]    second_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_x,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_y,
    output logic signed [spfp_pkg::DIRW-1:0]  dir_z,
    output logic signed [spfp_pkg::SVW-1:0]   support_value,
    output logic                              degenerate
);
    import spfp_pkg::*;

    logic [THRW-1:0] thr_reg;
    pair_t           pair;
    qpush_t          push;
    qent_t           q_head;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    assign pair.a = {first_z, first_y, first_x};
    assign pair.b = {second_z, second_y, second_x};

    spfp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pair     (pair),
        .q_full   (q_full),
        .push     (push)
    );

    spfp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (q_pop),
        .head  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    spfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .thr           (thr_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .dir_x         (dir_x),
        .dir_y         (dir_y),
        .dir_z         (dir_z),
        .support_value (support_value),
        .degenerate    (degenerate)
    );

endmodule

/* rtl/core/spfp_checker.sv */
// Port-level checks for the support plane core, bound to the top level.
// Depends on spfp_pkg for widths.
module spfp_port_checks (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [spfp_pkg::DIRW-1:0]  dir_x,
    input  logic signed [spfp_pkg::DIRW-1:0]  dir_y,
    input  logic signed [spfp_pkg::DIRW-1:0]  dir_z,
    input  logic signed [spfp_pkg::SVW-1:0]   support_value,
    input  logic                              degenerate
);
    import spfp_pkg::*;

    localparam logic signed [DIRW-1:0] ONE  = DIRW'(1) << DFB;
    localparam logic signed [DIRW-1:0] MONE = -(DIRW'(1) << DFB);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dir_x) && $stable(dir_y)
            && $stable(dir_z) && $stable(support_value) && $stable(degenerate))
        else $error("stalled result changed");

    // A degenerate pair gives zeros
    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> dir_x == '0 && dir_y == '0 && dir_z == '0
            && support_value == '0)
        else $error("degenerate result not zero");

    // The plane faces the first point
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !support_value[SVW-1])
        else $error("negative support value");

    // Unit components stay within one
    a_unit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dir_x <= ONE && dir_x >= MONE && dir_y <= ONE && dir_y >= MONE
            && dir_z <= ONE && dir_z >= MONE)
        else $error("direction component out of range");

endmodule

bind support_plane_from_two_points_core spfp_port_checks u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .support_value (support_value),
    .degenerate    (degenerate)
);
